FILE: rtl/octave_band_sound_level_meter_macros.svh
// Assertion macros for the octave band sound level meter checker.
// Expects signals named clk and rst_n in the scope where a macro is used.
`ifndef OCTAVE_BAND_SOUND_LEVEL_METER_MACROS_SVH
`define OCTAVE_BAND_SOUND_LEVEL_METER_MACROS_SVH

// Check a property on every clock edge outside of reset
`define OBSLM_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("obslm assertion failed");

// Check a property on every clock edge, reset included
`define OBSLM_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("obslm assertion failed");

`endif

FILE: rtl/obslm_pkg.sv
// Shared constants, codes, types and helpers of the sound level meter.
// No dependencies; imported by all files but the macro header.
package obslm_pkg;

  localparam int BANDS      = 8;
  localparam int COUNT_BITS = 16;

  localparam int BIDX_W  = (BANDS > 1) ? $clog2(BANDS) : 1;
  localparam int IDX_W   = $clog2(BANDS + 3);
  localparam int E_W     = 32;
  localparam int WT_W    = 16;
  localparam int V_W     = 36;
  localparam int FRAME_W = 40;
  localparam int BACC_W  = 36 + COUNT_BITS;
  localparam int TOTAL_W = 40 + COUNT_BITS;
  localparam int LVL_W   = 16;
  localparam int FC_W    = 16;

  localparam logic [WT_W-1:0]  UNITY_WEIGHT = 16'd4096;
  localparam logic [24:0]      LOG_SCALE    = 25'd19728296;
  localparam logic [47:0]      LEVEL_OFFSET = 48'd155126189;
  localparam logic [LVL_W-1:0] FLOOR_LEVEL  = 16'h8000;

  // Input modes
  localparam logic [1:0] MODE_ENERGY = 2'd0;
  localparam logic [1:0] MODE_REPORT = 2'd1;
  localparam logic [1:0] MODE_WEIGHT = 2'd2;

  // Result kinds
  localparam logic [1:0] KIND_BAND = 2'd0;
  localparam logic [1:0] KIND_AVG  = 2'd1;
  localparam logic [1:0] KIND_MIN  = 2'd2;
  localparam logic [1:0] KIND_MAX  = 2'd3;

  // Request from the sequencer to the band store
  typedef struct packed {
    logic              rd_en;
    logic [BIDX_W-1:0] rd_addr;
    logic              acc_we;
    logic [BIDX_W-1:0] acc_waddr;
    logic              wt_we;
    logic [BIDX_W-1:0] wt_addr;
    logic              acc_clr;
  } store_req_t;

  // Clamp the frame count to the 16-bit result field
  function automatic logic [FC_W-1:0] sat_count(input logic [COUNT_BITS-1:0] c);
    logic [COUNT_BITS:0] lim;
    lim = (COUNT_BITS + 1)'(65535);
    if ({1'b0, c} > lim) sat_count = '1;
    else sat_count = FC_W'(c);
  endfunction

endpackage

FILE: rtl/obslm_ifs.sv
// Valid/ready channel interfaces for input items and result items.
// Depends on obslm_pkg for field widths.
interface obslm_in_if import obslm_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [1:0]       mode;
  logic [2:0]       band;
  logic [E_W-1:0]   energy;
  logic             last_band;
  logic [WT_W-1:0]  weight_value;

  modport source(output valid, mode, band, energy, last_band, weight_value,
                 input ready);
  modport sink(input valid, mode, band, energy, last_band, weight_value,
               output ready);
endinterface

interface obslm_out_if import obslm_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [1:0]              kind;
  logic [2:0]              band_index;
  logic signed [LVL_W-1:0] level_centi_db;
  logic [FC_W-1:0]         frame_count;
  logic                    floor_flag;
  logic                    last;

  modport source(output valid, kind, band_index, level_centi_db, frame_count,
                 floor_flag, last, input ready);
  modport sink(input valid, kind, band_index, level_centi_db, frame_count,
               floor_flag, last, output ready);
endinterface

FILE: rtl/obslm_store.sv
// Band store: weight table and band accumulators in synchronous memories.
// Depends on obslm_pkg; entries never written since reset/clear read as reset value.
module obslm_store import obslm_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  store_req_t        req,
  input  logic [BACC_W-1:0] acc_wdata,
  input  logic [WT_W-1:0]   wt_wdata,
  output logic [BACC_W-1:0] acc_q,
  output logic [WT_W-1:0]   wt_q
);

  logic [BACC_W-1:0] acc_mem [BANDS];
  logic [WT_W-1:0]   wt_mem  [BANDS];
  logic [BANDS-1:0]  acc_vld_r;
  logic [BANDS-1:0]  wt_vld_r;

  // Track written entries; clear drops all accumulators at once
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_vld_r <= '0;
      wt_vld_r  <= '0;
    end else begin
      if (req.acc_clr) begin
        acc_vld_r <= '0;
      end else if (req.acc_we) begin
        acc_vld_r[req.acc_waddr] <= 1'b1;
      end
      if (req.wt_we) begin
        wt_vld_r[req.wt_addr] <= 1'b1;
      end
    end
  end

  // Write ports
  always_ff @(posedge clk) begin
    if (req.acc_we) begin
      acc_mem[req.acc_waddr] <= acc_wdata;
    end
    if (req.wt_we) begin
      wt_mem[req.wt_addr] <= wt_wdata;
    end
  end

  // Registered read, hold last data when idle
  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      acc_q <= acc_vld_r[req.rd_addr] ? acc_mem[req.rd_addr] : '0;
      wt_q  <= wt_vld_r[req.rd_addr] ? wt_mem[req.rd_addr] : UNITY_WEIGHT;
    end
  end

endmodule

FILE: rtl/obslm_div.sv
// Restoring divider, one quotient bit per cycle, for averages.
// Depends on obslm_pkg; divisor must be nonzero.
module obslm_div import obslm_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [TOTAL_W-1:0]    dividend,
  input  logic [COUNT_BITS-1:0] divisor,
  output logic                  done,
  output logic [TOTAL_W-1:0]    quotient
);

  localparam int CNT_W = $clog2(TOTAL_W + 1);

  logic                  busy_r;
  logic [CNT_W-1:0]      cnt_r;
  logic [TOTAL_W-1:0]    q_r;
  logic [COUNT_BITS:0]   rem_r;
  logic [COUNT_BITS-1:0] dvs_r;
  logic                  done_r;
  logic [COUNT_BITS+1:0] rem_sh;
  logic                  fits;

  // Shift in the next dividend bit and try the subtract
  assign rem_sh = {rem_r, q_r[TOTAL_W-1]};
  assign fits   = rem_sh >= {2'b00, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(TOTAL_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      q_r   <= {q_r[TOTAL_W-2:0], fits};
      rem_r <= fits ? (COUNT_BITS + 1)'(rem_sh - {2'b00, dvs_r})
                    : (COUNT_BITS + 1)'(rem_sh);
    end
  end

  assign done     = done_r;
  assign quotient = q_r;

endmodule

FILE: rtl/obslm_log.sv
// Level unit: log2 by normalization and repeated squaring, scaled to centi-dB.
// Depends on obslm_pkg; input must be nonzero.
module obslm_log import obslm_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [TOTAL_W-1:0] x,
  output logic               done,
  output logic [LVL_W-1:0]   level
);

  localparam int EXP_W = $clog2(TOTAL_W);
  localparam int L_W   = EXP_W + 16;
  localparam int P_W   = L_W + 25;

  typedef enum logic [5:0] {
    L_IDLE = 6'b000001,
    L_NORM = 6'b000010,
    L_SQ   = 6'b000100,
    L_CHK  = 6'b001000,
    L_MUL  = 6'b010000,
    L_FIN  = 6'b100000
  } lstate_t;

  lstate_t            st_r;
  logic [TOTAL_W-1:0] xs_r;
  logic [EXP_W-1:0]   e_r;
  logic [31:0]        m_r;
  logic [63:0]        sq_r;
  logic [15:0]        frac_r;
  logic [3:0]         bit_r;
  logic [P_W-1:0]     pr_r;
  logic               done_r;
  logic [LVL_W-1:0]   level_r;
  logic [32:0]        mm;
  logic [47:0]        acc;

  assign mm  = sq_r[63:31];
  assign acc = 48'(pr_r) + (LEVEL_OFFSET << 16) + 48'h0000_8000_0000;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= L_IDLE;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      case (st_r)
        L_IDLE: begin
          if (start) st_r <= L_NORM;
        end
        // Shift left until the top bit is set
        L_NORM: begin
          if (xs_r[TOTAL_W-1]) st_r <= L_SQ;
        end
        L_SQ: st_r <= L_CHK;
        L_CHK: begin
          if (bit_r == 4'd0) st_r <= L_MUL;
          else st_r <= L_SQ;
        end
        L_MUL: st_r <= L_FIN;
        L_FIN: begin
          st_r   <= L_IDLE;
          done_r <= 1'b1;
        end
        default: st_r <= L_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (st_r)
      L_IDLE: begin
        xs_r   <= x;
        e_r    <= EXP_W'(TOTAL_W - 1);
        frac_r <= '0;
        bit_r  <= 4'd15;
      end
      L_NORM: begin
        if (!xs_r[TOTAL_W-1]) begin
          xs_r <= {xs_r[TOTAL_W-2:0], 1'b0};
          e_r  <= e_r - 1'b1;
        end else begin
          m_r <= xs_r[TOTAL_W-1 -: 32];
        end
      end
      // Square the mantissa
      L_SQ: sq_r <= 64'(m_r) * 64'(m_r);
      // Renormalize and emit one fraction bit
      L_CHK: begin
        if (mm[32]) begin
          m_r            <= mm[32:1];
          frac_r[bit_r]  <= 1'b1;
        end else begin
          m_r <= mm[31:0];
        end
        bit_r <= bit_r - 1'b1;
      end
      L_MUL: pr_r <= P_W'({e_r, frac_r}) * P_W'(LOG_SCALE);
      L_FIN: begin
        if (acc[47:32] > 16'd32767) level_r <= 16'd32767;
        else level_r <= acc[47:32];
      end
      default: ;
    endcase
  end

  assign done  = done_r;
  assign level = level_r;

endmodule

FILE: rtl/octave_band_sound_level_meter.sv
// Weighted octave band sound level meter, top level.
// Channels: in_bus (sink) takes words with mode/band/energy/last_band/
// weight_value; out_bus (source) gives result words kind/band_index/
// level_centi_db/frame_count/floor_flag/last. Word moves on valid && ready.
// An energy word passes accept with store read, weight multiply, then
// saturating accumulate and write back to the band store. A weight word is
// written as it is accepted. Mode 3 words, out-of-range bands and energy
// words once the frame count is at its maximum are dropped. A report word
// walks BANDS+3 results; each takes a store read, the divider (averages
// only) and the level unit (normalize, squaring and scaling steps), then
// waits for the output register to free.
// in_bus.ready is high only between items; one item is in work at a time.
// Results sit in one output register, so a new item is taken while the final
// report word still waits. A stalled receiver holds the report walk.
// Reset: weights read as unity, accumulators zero, minimum all ones, count
// zero; all are set by the synchronous reset itself, no clearing pass.
module octave_band_sound_level_meter import obslm_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  obslm_in_if.sink    in_bus,
  obslm_out_if.source out_bus
);

  typedef enum logic [7:0] {
    S_IDLE   = 8'b00000001,
    S_MUL    = 8'b00000010,
    S_ACC    = 8'b00000100,
    S_RP_RD  = 8'b00001000,
    S_RP_SEL = 8'b00010000,
    S_RP_DIV = 8'b00100000,
    S_RP_LOG = 8'b01000000,
    S_RP_OUT = 8'b10000000
  } state_t;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  state_t                st_r;
  logic [BIDX_W-1:0]     band_r;
  logic [E_W-1:0]        energy_r;
  logic                  lastb_r;
  logic [V_W-1:0]        v_r;
  logic [FRAME_W-1:0]    frame_r;
  logic [TOTAL_W-1:0]    total_r;
  logic [FRAME_W-1:0]    min_r;
  logic [FRAME_W-1:0]    max_r;
  logic [COUNT_BITS-1:0] count_r;
  logic [IDX_W-1:0]      idx_r;
  logic [LVL_W-1:0]      lvl_r;
  logic                  flo_r;

  logic                  out_valid_r;
  logic [1:0]            out_kind_r;
  logic [2:0]            out_band_r;
  logic [LVL_W-1:0]      out_lvl_r;
  logic [FC_W-1:0]       out_fc_r;
  logic                  out_flo_r;
  logic                  out_last_r;

  store_req_t            req;
  logic [BACC_W-1:0]     acc_q;
  logic [WT_W-1:0]       wt_q;
  logic [BACC_W-1:0]     acc_wdata;

  logic                  in_acc;
  logic                  band_ok;
  logic                  mvalid;
  logic                  is_band;
  logic                  is_final;
  logic                  out_free;
  logic [TOTAL_W-1:0]    sel_x;
  logic                  div_go;
  logic                  div_done;
  logic [TOTAL_W-1:0]    quo;
  logic                  log_go;
  logic                  log_done;
  logic [TOTAL_W-1:0]    log_x;
  logic [LVL_W-1:0]      log_lvl;
  logic [BACC_W:0]       bsum;
  logic [FRAME_W:0]      fsum;
  logic [FRAME_W-1:0]    frame_new;
  logic [TOTAL_W:0]      tsum;
  logic [E_W+WT_W-1:0]   prod;

  assign in_acc   = in_bus.valid && in_bus.ready;
  assign band_ok  = (5'(in_bus.band) < 5'(BANDS));
  assign mvalid   = (count_r != '0);
  assign is_band  = (idx_r < IDX_W'(BANDS));
  assign is_final = (idx_r == IDX_W'(BANDS + 2));
  assign out_free = !out_valid_r || out_bus.ready;
  assign in_bus.ready = (st_r == S_IDLE);

  // Band store requests
  always_comb begin
    req.rd_en     = (in_acc && in_bus.mode == MODE_ENERGY) ||
                    (st_r == S_RP_RD && is_band);
    req.rd_addr   = (st_r == S_IDLE) ? BIDX_W'(in_bus.band) : BIDX_W'(idx_r);
    req.acc_we    = (st_r == S_ACC);
    req.acc_waddr = band_r;
    req.wt_we     = in_acc && in_bus.mode == MODE_WEIGHT && band_ok;
    req.wt_addr   = BIDX_W'(in_bus.band);
    req.acc_clr   = (st_r == S_RP_OUT) && out_free && is_final;
  end

  obslm_store u_store (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (req),
    .acc_wdata (acc_wdata),
    .wt_wdata  (in_bus.weight_value),
    .acc_q     (acc_q),
    .wt_q      (wt_q)
  );

  // Weighted energy and saturating sums
  assign prod      = (E_W + WT_W)'(energy_r) * (E_W + WT_W)'(wt_q);
  assign bsum      = {1'b0, acc_q} + (BACC_W + 1)'(v_r);
  assign acc_wdata = bsum[BACC_W] ? '1 : bsum[BACC_W-1:0];
  assign fsum      = {1'b0, frame_r} + (FRAME_W + 1)'(v_r);
  assign frame_new = fsum[FRAME_W] ? '1 : fsum[FRAME_W-1:0];
  assign tsum      = {1'b0, total_r} + (TOTAL_W + 1)'(frame_new);

  // Report operand select
  always_comb begin
    if (is_band) sel_x = TOTAL_W'(acc_q);
    else if (idx_r == IDX_W'(BANDS)) sel_x = total_r;
    else if (idx_r == IDX_W'(BANDS + 1)) sel_x = TOTAL_W'(min_r);
    else sel_x = TOTAL_W'(max_r);
  end

  assign div_go = (st_r == S_RP_SEL) && mvalid && (idx_r <= IDX_W'(BANDS));
  assign log_go = ((st_r == S_RP_SEL) && mvalid && (idx_r > IDX_W'(BANDS)) &&
                   (sel_x != '0)) ||
                  ((st_r == S_RP_DIV) && div_done && (quo != '0));
  assign log_x  = (st_r == S_RP_SEL) ? sel_x : quo;

  obslm_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_go),
    .dividend (sel_x),
    .divisor  (count_r),
    .done     (div_done),
    .quotient (quo)
  );

  obslm_log u_log (
    .clk   (clk),
    .rst_n (rst_n),
    .start (log_go),
    .x     (log_x),
    .done  (log_done),
    .level (log_lvl)
  );

  // Sequencer and measurement state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= S_IDLE;
      frame_r <= '0;
      total_r <= '0;
      min_r   <= '1;
      max_r   <= '0;
      count_r <= '0;
      idx_r   <= '0;
    end else begin
      case (st_r)
        S_IDLE: begin
          if (in_acc) begin
            if (in_bus.mode == MODE_ENERGY && band_ok && count_r < COUNT_MAX) begin
              st_r <= S_MUL;
            end else if (in_bus.mode == MODE_REPORT) begin
              idx_r <= '0;
              st_r  <= S_RP_RD;
            end
          end
        end
        S_MUL: st_r <= S_ACC;
        // Accumulate and close the frame on the last band
        S_ACC: begin
          st_r <= S_IDLE;
          if (lastb_r) begin
            count_r <= count_r + 1'b1;
            if (frame_new < min_r) min_r <= frame_new;
            if (frame_new > max_r) max_r <= frame_new;
            total_r <= tsum[TOTAL_W] ? '1 : tsum[TOTAL_W-1:0];
            frame_r <= '0;
          end else begin
            frame_r <= frame_new;
          end
        end
        S_RP_RD: st_r <= S_RP_SEL;
        S_RP_SEL: begin
          if (div_go) st_r <= S_RP_DIV;
          else if (log_go) st_r <= S_RP_LOG;
          else st_r <= S_RP_OUT;
        end
        S_RP_DIV: begin
          if (div_done) st_r <= (quo != '0) ? S_RP_LOG : S_RP_OUT;
        end
        S_RP_LOG: begin
          if (log_done) st_r <= S_RP_OUT;
        end
        // Hand the word to the output register, then step or clear
        S_RP_OUT: begin
          if (out_free) begin
            if (is_final) begin
              st_r    <= S_IDLE;
              frame_r <= '0;
              total_r <= '0;
              min_r   <= '1;
              max_r   <= '0;
              count_r <= '0;
            end else begin
              idx_r <= idx_r + 1'b1;
              st_r  <= S_RP_RD;
            end
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  // Item and result payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      band_r   <= BIDX_W'(in_bus.band);
      energy_r <= in_bus.energy;
      lastb_r  <= in_bus.last_band;
    end
    if (st_r == S_MUL) begin
      v_r <= prod[E_W+WT_W-1:12];
    end
    if (st_r == S_RP_SEL && !log_go && !div_go) begin
      lvl_r <= FLOOR_LEVEL;
      flo_r <= 1'b1;
    end else if (st_r == S_RP_DIV && div_done && quo == '0) begin
      lvl_r <= FLOOR_LEVEL;
      flo_r <= 1'b1;
    end else if (st_r == S_RP_LOG && log_done) begin
      lvl_r <= log_lvl;
      flo_r <= 1'b0;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (st_r == S_RP_OUT && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_bus.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (st_r == S_RP_OUT && out_free) begin
      if (is_band) out_kind_r <= KIND_BAND;
      else if (idx_r == IDX_W'(BANDS)) out_kind_r <= KIND_AVG;
      else if (idx_r == IDX_W'(BANDS + 1)) out_kind_r <= KIND_MIN;
      else out_kind_r <= KIND_MAX;
      out_band_r <= is_band ? 3'(idx_r) : 3'd0;
      out_lvl_r  <= lvl_r;
      out_fc_r   <= sat_count(count_r);
      out_flo_r  <= flo_r;
      out_last_r <= is_final;
    end
  end

  assign out_bus.valid          = out_valid_r;
  assign out_bus.kind           = out_kind_r;
  assign out_bus.band_index     = out_band_r;
  assign out_bus.level_centi_db = out_lvl_r;
  assign out_bus.frame_count    = out_fc_r;
  assign out_bus.floor_flag     = out_flo_r;
  assign out_bus.last           = out_last_r;

endmodule

FILE: rtl/obslm_checker.sv
// Port-level checker for the sound level meter result channel, with bind.
// Depends on obslm_pkg and octave_band_sound_level_meter_macros.svh.
`include "octave_band_sound_level_meter_macros.svh"

module obslm_checker import obslm_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             out_valid,
  input logic             out_ready,
  input logic [1:0]       out_kind,
  input logic [2:0]       out_band_index,
  input logic [LVL_W-1:0] out_level,
  input logic             out_floor_flag,
  input logic             out_last
);

  // Hold a stalled word
  `OBSLM_ASSERT(a_valid_hold, out_valid && !out_ready |=> out_valid)
  `OBSLM_ASSERT(a_level_hold, out_valid && !out_ready |=> $stable(out_level))
  // A floor result carries the floor level
  `OBSLM_ASSERT(a_floor_level, out_valid && out_floor_flag |-> out_level == FLOOR_LEVEL)
  // The closing word of a report is the maximum
  `OBSLM_ASSERT(a_last_max, out_valid && out_last |-> out_kind == KIND_MAX)
  // Only band averages name a band
  `OBSLM_ASSERT(a_band_zero, out_valid && out_kind != KIND_BAND |-> out_band_index == 3'd0)

endmodule

bind octave_band_sound_level_meter obslm_checker u_obslm_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_bus.valid),
  .out_ready      (out_bus.ready),
  .out_kind       (out_bus.kind),
  .out_band_index (out_bus.band_index),
  .out_level      (out_bus.level_centi_db),
  .out_floor_flag (out_bus.floor_flag),
  .out_last       (out_bus.last)
);

FILE: verif/octave_band_sound_level_meter_tb.sv
// Testbench for the octave band sound level meter: drives energy, weight and
// report words, predicts every result word and compares them field by field.
// Depends on obslm_pkg, obslm_ifs and the octave_band_sound_level_meter RTL.
`timescale 1ns / 1ps

module octave_band_sound_level_meter_tb;
  import obslm_pkg::*;

  localparam logic [63:0] FRAME_MAX = (64'd1 << FRAME_W) - 1;
  localparam logic [63:0] BACC_MAX  = (64'd1 << BACC_W) - 1;
  localparam logic [63:0] TOTAL_MAX = (64'd1 << TOTAL_W) - 1;
  localparam logic [31:0] COUNT_MAX = (32'd1 << COUNT_BITS) - 1;
  localparam logic [1:0]  MODE_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0]       kind;
    logic [2:0]       band_index;
    logic [LVL_W-1:0] level;
    logic [FC_W-1:0]  frame_count;
    logic             floor_flag;
    logic             last;
  } level_word_t;

  logic clk;
  logic rst_n;

  obslm_in_if  in_ch();
  obslm_out_if out_ch();

  octave_band_sound_level_meter DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_bus (in_ch.sink),
    .out_bus(out_ch.source)
  );

  // Model state of the meter
  logic [WT_W-1:0] gain_tab [BANDS];
  logic [63:0]     band_sum [BANDS];
  logic [63:0]     open_frame;
  logic [63:0]     grand_sum;
  logic [63:0]     quietest;
  logic [63:0]     loudest;
  logic [31:0]     frames;

  level_word_t pending_levels[$];
  int          mismatches;
  int          sink_hold;      // long receiver hold-off, in cycles
  bit          no_gaps;        // disable random idling on both sides

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic logic [63:0] add_clamp(logic [63:0] a, logic [63:0] b,
                                            logic [63:0] top);
    if (a > top) a = top;
    if (b > top - a) return top;
    return a + b;
  endfunction

  function automatic void clear_meter();
    for (int i = 0; i < BANDS; i++) band_sum[i] = '0;
    open_frame = '0;
    grand_sum  = '0;
    quietest   = FRAME_MAX;
    loudest    = '0;
    frames     = '0;
  endfunction

  // log2 by normalize and repeated squaring, then scale to centi-dB SPL
  function automatic logic [LVL_W-1:0] centi_db(logic [63:0] x);
    int unsigned e;
    logic [63:0] m, l, acc;
    e = 63;
    while (e > 0 && x[e] == 1'b0) e--;
    if (e >= 31) m = x >> (e - 31);
    else m = x << (31 - e);
    l = 64'(e) << 16;
    for (int i = 15; i >= 0; i--) begin
      m = (m * m) >> 31;
      if (m >= (64'd1 << 32)) begin
        m = m >> 1;
        l[i] = 1'b1;
      end
    end
    acc = l * 64'(LOG_SCALE) + (64'(LEVEL_OFFSET) << 16) + (64'd1 << 31);
    acc = acc >> 32;
    if (acc > 64'd32767) acc = 64'd32767;
    return acc[15:0];
  endfunction

  function automatic void queue_level(logic [1:0] kind, logic [2:0] band,
                                      logic [63:0] energy, bit valid, bit last);
    level_word_t w;
    bit flo;
    flo = !valid || energy == 0;
    w.kind        = kind;
    w.band_index  = band;
    w.level       = flo ? FLOOR_LEVEL : centi_db(energy);
    w.frame_count = (frames > 65535) ? 16'hFFFF : frames[15:0];
    w.floor_flag  = flo;
    w.last        = last;
    pending_levels.push_back(w);
  endfunction

  // Advance the model by one accepted word
  function automatic void meter_model(logic [1:0] mode, logic [2:0] band,
                                      logic [31:0] energy, logic last_band,
                                      logic [WT_W-1:0] wv);
    logic [63:0] v, n;
    bit valid;
    case (mode)
      MODE_ENERGY: begin
        if (band >= BANDS || frames >= COUNT_MAX) return;
        v = (64'(energy) * 64'(gain_tab[band])) >> 12;
        band_sum[band] = add_clamp(band_sum[band], v, BACC_MAX);
        open_frame = add_clamp(open_frame, v, FRAME_MAX);
        if (last_band) begin
          frames++;
          if (open_frame < quietest) quietest = open_frame;
          if (open_frame > loudest) loudest = open_frame;
          grand_sum = add_clamp(grand_sum, open_frame, TOTAL_MAX);
          open_frame = '0;
        end
      end
      MODE_WEIGHT: begin
        if (band < BANDS) gain_tab[band] = wv;
      end
      MODE_REPORT: begin
        valid = frames != 0;
        n = valid ? 64'(frames) : 64'd1;
        for (int i = 0; i < BANDS; i++)
          queue_level(KIND_BAND, 3'(i), band_sum[i] / n, valid, 1'b0);
        queue_level(KIND_AVG, 3'd0, grand_sum / n, valid, 1'b0);
        queue_level(KIND_MIN, 3'd0, quietest, valid, 1'b0);
        queue_level(KIND_MAX, 3'd0, loudest, valid, 1'b1);
        clear_meter();
      end
      default: ;
    endcase
  endfunction

  // Send one word; valid stays high into the next word when there is no gap
  task automatic send_word(logic [1:0] mode, logic [2:0] band, logic [31:0] energy,
                           logic last_band, logic [WT_W-1:0] wv);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.mode         <= mode;
    in_ch.band         <= band;
    in_ch.energy       <= energy;
    in_ch.last_band    <= last_band;
    in_ch.weight_value <= wv;
    do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
    meter_model(mode, band, energy, last_band, wv);
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (pending_levels.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic send_frame(logic [31:0] emax);
    for (int b = 0; b < BANDS; b++)
      send_word(MODE_ENERGY, 3'(b), $urandom_range(0, emax), b == BANDS - 1, '0);
  endtask

  // Receiver: random stalls, plus a long hold-off when requested
  initial begin
    int gap;
    out_ch.ready <= 1'b0;
    @(posedge rst_n);
    forever begin
      if (sink_hold > 0) begin
        out_ch.ready <= 1'b0;
        repeat (sink_hold) @(posedge clk);
        sink_hold = 0;
      end
      gap = no_gaps ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!(out_ch.valid && out_ch.ready) && sink_hold == 0);
    end
  end

  // Compare each result word with the oldest expectation
  always @(posedge clk) begin
    level_word_t want, got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.kind        = out_ch.kind;
      got.band_index  = out_ch.band_index;
      got.level       = out_ch.level_centi_db;
      got.frame_count = out_ch.frame_count;
      got.floor_flag  = out_ch.floor_flag;
      got.last        = out_ch.last;
      if (pending_levels.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word %p", got);
      end else begin
        want = pending_levels.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p actual %p", want, got);
        end
      end
    end
  end

  // Empty report, zero energy, extremes of energy and weight, unused mode
  task automatic test_directed();
    send_word(MODE_REPORT, 3'd0, '0, 1'b0, '0);
    drain_results();
    send_word(MODE_UNUSED, 3'd7, '1, 1'b1, '1);
    send_word(MODE_ENERGY, 3'd0, '0, 1'b1, '0);
    send_word(MODE_REPORT, 3'd0, '0, 1'b0, '0);
    send_word(MODE_WEIGHT, 3'd0, '0, 1'b0, 16'hFFFF);
    send_word(MODE_WEIGHT, 3'd7, '0, 1'b0, 16'h0000);
    send_word(MODE_ENERGY, 3'd0, 32'hFFFF_FFFF, 1'b0, '0);
    send_word(MODE_ENERGY, 3'd7, 32'hFFFF_FFFF, 1'b0, '0);
    send_word(MODE_ENERGY, 3'd3, 32'd1, 1'b1, '0);
    send_word(MODE_ENERGY, 3'd3, 32'd1, 1'b1, '0);
    // open frame at report is discarded
    send_word(MODE_ENERGY, 3'd4, 32'h8000_0000, 1'b0, '0);
    send_word(MODE_REPORT, 3'd0, '0, 1'b0, '0);
    drain_results();
  endtask

  // Saturate the frame sum with max energy at max weight
  task automatic test_frame_saturation();
    for (int b = 0; b < BANDS; b++) send_word(MODE_WEIGHT, 3'(b), '0, 1'b0, 16'hFFFF);
    repeat (3)
      for (int i = 0; i < 20; i++)
        send_word(MODE_ENERGY, 3'(i % BANDS), 32'hFFFF_FFFF, i == 19, '0);
    send_word(MODE_REPORT, 3'd0, '0, 1'b0, '0);
    drain_results();
  endtask

  // Receiver holds off while the sender keeps offering words
  task automatic test_backpressure();
    send_frame(32'hFFFF_FFFF);
    sink_hold = 400;
    send_word(MODE_REPORT, 3'd0, '0, 1'b0, '0);
    send_frame(32'h00FF_FFFF);
    send_frame(32'hFFFF_FFFF);
    send_word(MODE_REPORT, 3'd0, '0, 1'b0, '0);
    drain_results();
  endtask

  // Mostly well-formed frames with random content, some weights and noise
  task automatic test_random();
    int sent, pick;
    sent = 0;
    while (sent < 160) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        send_frame(pick < 10 ? 32'h0000_FFFF : 32'hFFFF_FFFF);
        sent += BANDS;
      end else if (pick < 75) begin
        send_word(MODE_WEIGHT, 3'($urandom), '0, 1'b0,
                  ($urandom_range(0, 1) != 0) ? 16'($urandom) : UNITY_WEIGHT);
        sent++;
      end else if (pick < 88) begin
        send_word(MODE_ENERGY, 3'($urandom), $urandom, 1'($urandom), '0);
        sent++;
      end else if (pick < 93) begin
        send_word(MODE_UNUSED, 3'($urandom), $urandom, 1'($urandom), 16'($urandom));
      end else begin
        send_word(MODE_REPORT, 3'($urandom), $urandom, 1'($urandom), 16'($urandom));
        sent++;
        if (pick == 99) drain_results();
      end
    end
    send_word(MODE_REPORT, 3'd0, '0, 1'b0, '0);
    drain_results();
  endtask

  initial begin
    mismatches = 0;
    sink_hold  = 0;
    no_gaps    = 0;
    for (int i = 0; i < BANDS; i++) gain_tab[i] = UNITY_WEIGHT;
    clear_meter();
    rst_n              <= 1'b0;
    in_ch.valid        <= 1'b0;
    in_ch.mode         <= MODE_ENERGY;
    in_ch.band         <= '0;
    in_ch.energy       <= '0;
    in_ch.last_band    <= 1'b0;
    in_ch.weight_value <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_frame_saturation();
    test_backpressure();
    test_random();

    repeat (200) @(posedge clk);
    if (mismatches == 0 && pending_levels.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
